// ===== src/slcan_pkg.sv =====
// ----------------------------------------------------------------------------
// slcan_pkg: shared types and constants for the serial CAN bridge
// Holds character codes, the queue entry record and a hex helper.
// ----------------------------------------------------------------------------
package slcan_pkg;

    localparam logic [7:0] CH_BELL = 8'd7;
    localparam logic [7:0] CH_CR   = 8'd13;

    // Job kinds passed from the parser to the emitter
    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_FRAME,
        JOB_RXTEXT,
        JOB_VERSION,
        JOB_SERIAL,
        JOB_STATUS,
        JOB_SINGLE
    } t_job;

    typedef struct packed {
        t_job        kind;
        logic [7:0]  ch;
        logic [7:0]  resp;
        logic [31:0] id;
        logic [3:0]  len;
        logic        ext;
        logic        rmt;
        logic [63:0] data;
    } t_entry;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

endpackage

// ===== src/slcan_front.sv =====
// ----------------------------------------------------------------------------
// slcan_front: line parser
// Accepts items, keeps the line state and issues one job per response.
// ----------------------------------------------------------------------------
module slcan_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_op,
    input  logic [7:0]             i_char_in,
    input  logic                   i_end_of_line,
    input  logic [11:0]            i_rx_id,
    input  logic [3:0]             i_rx_length,
    input  logic [63:0]            i_rx_data,
    input  logic [7:0]             i_tx_space,
    output logic                   o_push,
    output slcan_pkg::t_entry      o_entry,
    input  logic                   i_full
);

    logic        r_ovf;
    logic [7:0]  r_pos;
    logic [7:0]  r_cmd;
    logic [7:0]  r_sec;
    logic [31:0] r_id;
    logic [3:0]  r_len;
    logic [63:0] r_data;
    logic        r_err;

    logic        acc;
    logic        is_frame, ext, rmt, hex_ok, sec_hex;
    logic [3:0]  hv, nb, rxl;
    logic [7:0]  idlen, need, k;
    logic [5:0]  sh;
    slcan_pkg::t_entry ent;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;

    // Decode hex digit of a character
    function automatic logic [4:0] hexv(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)      hexv = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            hexv = {1'b1, c[3:0] + 4'd9};
        else                               hexv = 5'd0;
    endfunction

    // Classify the current command
    always_comb begin
        logic [7:0] cc;
        cc       = (r_pos == 8'd0) ? i_char_in : r_cmd;
        is_frame = (cc == "t") || (cc == "T") || (cc == "r") || (cc == "R");
        ext      = cc < "Z";
        rmt      = (cc == "r") || (cc == "R");
        idlen    = ext ? 8'd8 : 8'd3;
        {hex_ok, hv} = hexv(i_char_in);
        sec_hex  = (hexv(r_sec) != 5'd0);
        nb       = (r_len > 4'd8) ? 4'd8 : r_len;
        need     = idlen + 8'd2 + (rmt ? 8'd0 : {3'd0, nb, 1'b0});
        k        = r_pos - idlen - 8'd2;
        sh       = {k[3:1], 3'd0} + (k[0] ? 6'd0 : 6'd4);
        rxl      = (i_rx_length > 4'd8) ? 4'd8 : i_rx_length;
    end

    // Build the job for this item
    always_comb begin
        ent      = '0;
        ent.kind = slcan_pkg::JOB_NONE;
        ent.resp = slcan_pkg::CH_BELL;
        if (i_op) begin
            if ({1'b0, i_tx_space} >= {3'd0, rxl, 1'b0} + 9'd5) begin
                ent.kind = slcan_pkg::JOB_RXTEXT;
                ent.id   = {20'd0, i_rx_id};
                ent.len  = rxl;
                ent.data = i_rx_data;
            end
        end else if (i_end_of_line) begin
            ent.kind = slcan_pkg::JOB_SINGLE;
            if (r_pos != 8'd0 && is_frame) begin
                if (!r_err && r_pos >= need) begin
                    ent.kind = slcan_pkg::JOB_FRAME;
                    ent.resp = slcan_pkg::CH_CR;
                    ent.id   = r_id;
                    ent.len  = r_len;
                    ent.ext  = ext;
                    ent.rmt  = rmt;
                    ent.data = rmt ? 64'd0 : r_data;
                end
            end else if (r_pos != 8'd0) begin
                case (r_cmd)
                    "S": if (r_pos >= 8'd2 && r_sec == "4") ent.resp = slcan_pkg::CH_CR;
                    "Z": if (r_pos >= 8'd2 && sec_hex) ent.resp = slcan_pkg::CH_CR;
                    "V", "v": begin
                        ent.kind = slcan_pkg::JOB_VERSION;
                        ent.ch   = r_cmd;
                    end
                    "N": ent.kind = slcan_pkg::JOB_SERIAL;
                    "F": begin
                        ent.kind = slcan_pkg::JOB_STATUS;
                        ent.ch   = r_ovf ? 8'h08 : 8'h00;
                    end
                    "s", "O", "l", "L", "C", "q", "Q", "P", "a", "A", "g", "G", "m", "M":
                        ent.resp = slcan_pkg::CH_CR;
                    default: ent.resp = slcan_pkg::CH_BELL;
                endcase
            end
        end
    end

    assign o_entry = ent;
    assign o_push  = acc && (ent.kind != slcan_pkg::JOB_NONE);

    // Advance the line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0; r_pos <= '0; r_cmd <= '0; r_sec <= '0;
            r_id <= '0; r_len <= '0; r_data <= '0; r_err <= 1'b0;
        end else if (acc) begin
            if (i_op) begin
                if (ent.kind == slcan_pkg::JOB_NONE) r_ovf <= 1'b1;
            end else if (i_end_of_line) begin
                if (ent.kind == slcan_pkg::JOB_STATUS) r_ovf <= 1'b0;
                r_pos <= '0; r_cmd <= '0; r_sec <= '0;
                r_id <= '0; r_len <= '0; r_data <= '0; r_err <= 1'b0;
            end else begin
                if (r_pos == 8'd0) r_cmd <= i_char_in;
                if (r_pos == 8'd1) r_sec <= i_char_in;
                if (r_pos >= 8'd1 && is_frame) begin
                    if (r_pos <= idlen) begin
                        if (!hex_ok) r_err <= 1'b1;
                        else         r_id  <= {r_id[27:0], hv};
                    end else if (r_pos == idlen + 8'd1) begin
                        if (!hex_ok) r_err <= 1'b1;
                        else         r_len <= hv;
                    end else if (!rmt && k < {3'd0, nb, 1'b0}) begin
                        if (!hex_ok) r_err <= 1'b1;
                        else         r_data <= r_data | ({60'd0, hv} << sh);
                    end
                end
                if (r_pos != 8'hFF) r_pos <= r_pos + 8'd1;
            end
        end
    end

endmodule

// ===== src/slcan_queue.sv =====
// ----------------------------------------------------------------------------
// slcan_queue: job queue
// Two-entry FIFO that decouples the parser from the emitter.
// ----------------------------------------------------------------------------
module slcan_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  slcan_pkg::t_entry  i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output slcan_pkg::t_entry  o_entry
);

    slcan_pkg::t_entry r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_entry = r_mem[r_rp];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    // Track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== src/slcan_back.sv =====
// ----------------------------------------------------------------------------
// slcan_back: response emitter
// Steps through the result items of one job, one per accepted output.
// ----------------------------------------------------------------------------
module slcan_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  slcan_pkg::t_entry  i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_out_kind,
    output logic [7:0]         o_out_char,
    output logic [31:0]        o_frame_id,
    output logic [3:0]         o_frame_length,
    output logic               o_frame_extended,
    output logic               o_frame_remote,
    output logic [63:0]        o_frame_data,
    output logic               o_last
);

    logic [4:0] r_step;
    logic [4:0] total;
    logic [7:0] ch;
    logic [2:0] bi;
    logic [7:0] byt;
    logic       fire;

    assign o_valid = !i_empty;
    assign fire    = o_valid && i_ready;

    // Pick the character of this step
    always_comb begin
        total = 5'd1;
        ch    = i_entry.resp;
        bi    = 3'(({1'b0, r_step} - 6'd5) >> 1);
        byt   = i_entry.data[{bi, 3'd0} +: 8];
        case (i_entry.kind)
            slcan_pkg::JOB_FRAME: begin
                total = 5'd3;
                if (r_step == 5'd1) ch = "z";
            end
            slcan_pkg::JOB_VERSION: begin
                total = 5'd6;
                case (r_step)
                    5'd0: ch = i_entry.ch;
                    5'd1, 5'd3, 5'd4: ch = "0";
                    5'd2: ch = "1";
                    default: ch = slcan_pkg::CH_CR;
                endcase
            end
            slcan_pkg::JOB_SERIAL: begin
                total = 5'd6;
                ch = (r_step == 5'd0) ? "N" : (r_step == 5'd5) ? slcan_pkg::CH_CR : "F";
            end
            slcan_pkg::JOB_STATUS: begin
                total = 5'd4;
                case (r_step)
                    5'd0: ch = "F";
                    5'd1: ch = slcan_pkg::hex_char(i_entry.ch[7:4]);
                    5'd2: ch = slcan_pkg::hex_char(i_entry.ch[3:0]);
                    default: ch = slcan_pkg::CH_CR;
                endcase
            end
            slcan_pkg::JOB_RXTEXT: begin
                total = {i_entry.len, 1'b0} + 5'd6;
                if (r_step == 5'd0)      ch = "t";
                else if (r_step <= 5'd3)
                    ch = slcan_pkg::hex_char(i_entry.id[4'(5'd11 - {r_step - 5'd1, 2'd0}) -: 4]);
                else if (r_step == 5'd4) ch = slcan_pkg::hex_char(i_entry.len);
                else if (r_step == total - 5'd1) ch = slcan_pkg::CH_CR;
                else ch = slcan_pkg::hex_char(r_step[0] ? byt[7:4] : byt[3:0]);
            end
            default: ch = i_entry.resp;
        endcase
    end

    // Drive the result fields
    always_comb begin
        o_last           = r_step == total - 5'd1;
        o_out_kind       = 1'b0;
        o_out_char       = ch;
        o_frame_id       = '0;
        o_frame_length   = '0;
        o_frame_extended = 1'b0;
        o_frame_remote   = 1'b0;
        o_frame_data     = '0;
        if (i_entry.kind == slcan_pkg::JOB_FRAME && r_step == 5'd0) begin
            o_out_kind       = 1'b1;
            o_out_char       = '0;
            o_frame_id       = i_entry.id;
            o_frame_length   = i_entry.len;
            o_frame_extended = i_entry.ext;
            o_frame_remote   = i_entry.rmt;
            o_frame_data     = i_entry.data;
        end
    end

    assign o_pop = fire && o_last;

    // Advance through the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (fire) begin
            r_step <= o_last ? 5'd0 : r_step + 5'd1;
        end
    end

endmodule

// ===== src/slcan_serial_can_bridge_unit.sv =====
// ----------------------------------------------------------------------------
// slcan_serial_can_bridge_unit: ASCII serial to CAN bridge
// Parses slcan command lines and formats received CAN frames as text.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one serial character, line terminator or
// received CAN frame per request. Characters without terminator only update
// the line state and produce nothing.
// Output channel (o_valid/i_ready): one result per request, either a serial
// character or a CAN frame to transmit; o_last marks the final result of an
// input item.
// Throughput: one input per cycle while the two-entry job queue has room.
// A response starts once its job is registered in the queue and reaches the
// emitter, then one result per cycle while the receiver is ready.
// The emitter holds each job until its last result is taken.
// A stalled receiver fills the queue, then o_ready drops; nothing is lost.
// Reset clears the line state, the overflow flag and the queue.
// ----------------------------------------------------------------------------
module slcan_serial_can_bridge_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_line,
    input  logic [11:0] i_rx_id,
    input  logic [3:0]  i_rx_length,
    input  logic [63:0] i_rx_data,
    input  logic [7:0]  i_tx_space,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_out_char,
    output logic [31:0] o_frame_id,
    output logic [3:0]  o_frame_length,
    output logic        o_frame_extended,
    output logic        o_frame_remote,
    output logic [63:0] o_frame_data,
    output logic        o_last
);

    logic              push, full, pop, empty;
    slcan_pkg::t_entry f_entry, q_entry;

    slcan_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_op, .i_char_in, .i_end_of_line, .i_rx_id, .i_rx_length,
        .i_rx_data, .i_tx_space,
        .o_push(push), .o_entry(f_entry), .i_full(full)
    );

    slcan_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_entry(f_entry), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_entry(q_entry)
    );

    slcan_back u_back (
        .i_clk, .i_rst_n,
        .i_empty(empty), .i_entry(q_entry), .o_pop(pop),
        .o_valid, .i_ready,
        .o_out_kind, .o_out_char, .o_frame_id, .o_frame_length,
        .o_frame_extended, .o_frame_remote, .o_frame_data, .o_last
    );

endmodule

// ===== src/slcan_checker.sv =====
// ----------------------------------------------------------------------------
// slcan_checker: port-level checks for the bridge
// Watches the output channel and result framing over time.
// ----------------------------------------------------------------------------
module slcan_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_out_kind,
    input logic [7:0]  o_out_char,
    input logic        o_last
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char))
        else $error("stalled result changed");

    // A frame result is never the last one
    a_frame_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind |-> !o_last)
        else $error("frame result marked last");

    // A frame result is followed by 'z'
    a_frame_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_out_kind |=> o_valid && o_out_char == "z")
        else $error("frame not followed by z");

    // The last result ends in CR or BELL
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_out_char == slcan_pkg::CH_CR ||
                              o_out_char == slcan_pkg::CH_BELL)
        else $error("last result not CR or BELL");

endmodule

bind slcan_serial_can_bridge_unit slcan_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_out_kind, .o_out_char, .o_last
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the serial CAN bridge
// Drives serial lines and received frames with random idling on both sides
// and checks every response against an in-bench line parser model.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FRAME = 1'b1;
    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [31:0] id;
        logic [3:0]  len;
        logic        ext;
        logic        rmt;
        logic [63:0] data;
        logic        last;
    } t_result;

    typedef struct {
        logic        op;
        logic [7:0]  ch;
        logic        eol;
        logic [11:0] rx_id;
        logic [3:0]  rx_len;
        logic [63:0] rx_data;
        logic [7:0]  space;
        logic [7:0]  known_ch;  // typed-in single response, 0 = use model
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = 1'b0;
    logic [7:0]  i_char_in = '0;
    logic        i_end_of_line = 1'b0;
    logic [11:0] i_rx_id = '0;
    logic [3:0]  i_rx_length = '0;
    logic [63:0] i_rx_data = '0;
    logic [7:0]  i_tx_space = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_out_char;
    logic [31:0] o_frame_id;
    logic [3:0]  o_frame_length;
    logic        o_frame_extended;
    logic        o_frame_remote;
    logic [63:0] o_frame_data;
    logic        o_last;

    slcan_serial_can_bridge_unit i_dut (.*);

    always #10 i_clk = ~i_clk;

    // Parser state mirror
    logic        ovf;
    logic [7:0]  pos, cmd, arg;
    logic [31:0] id_acc;
    logic [3:0]  len_code;
    logic [63:0] data_acc;
    logic        bad_hex;

    t_result    pending_results[$];
    t_request   stim[$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         in_done = 0;

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        return (v < 10) ? 8'h30 + v : 8'h37 + v;
    endfunction

    function automatic bit frame_cmd(logic [7:0] c);
        return c == "t" || c == "T" || c == "r" || c == "R";
    endfunction

    task automatic push_char(logic [7:0] c);
        t_result r;
        r = '0;
        r.kind = KIND_CHAR;
        r.ch = c;
        pending_results.push_back(r);
    endtask

    task automatic push_hex(logic [7:0] v);
        push_char(hex_digit(v[7:4]));
        push_char(hex_digit(v[3:0]));
    endtask

    task automatic clear_line();
        pos = 0; cmd = 0; arg = 0; id_acc = 0; len_code = 0; data_acc = 0;
        bad_hex = 0;
    endtask

    // Consume a line character
    task automatic parse_char(logic [7:0] c);
        int idlen, v, k, nb;
        bit rm;
        if (pos == 0) cmd = c;
        else if (pos == 1) arg = c;
        if (pos >= 1 && frame_cmd(cmd)) begin
            idlen = (cmd < "Z") ? 8 : 3;
            rm = cmd == "r" || cmd == "R";
            v = hex_value(c);
            if (pos <= idlen) begin
                if (v < 0) bad_hex = 1;
                else id_acc = {id_acc[27:0], 4'(v)};
            end else if (pos == idlen + 1) begin
                if (v < 0) bad_hex = 1;
                else len_code = 4'(v);
            end else if (!rm) begin
                k = pos - idlen - 2;
                nb = (len_code > 8) ? 8 : len_code;
                if (k < 2 * nb) begin
                    if (v < 0) bad_hex = 1;
                    else data_acc |= 64'(v) << (8 * (k / 2) + ((k % 2) ? 0 : 4));
                end
            end
        end
        if (pos < 255) pos++;
    endtask

    // Execute the line and queue the response
    task automatic run_line();
        logic [7:0] resp;
        int idlen, nb, need;
        bit rm;
        t_result r;
        resp = slcan_pkg::CH_BELL;
        if (pos == 0) begin
            resp = slcan_pkg::CH_BELL;
        end else if (frame_cmd(cmd)) begin
            idlen = (cmd < "Z") ? 8 : 3;
            rm = cmd == "r" || cmd == "R";
            nb = (len_code > 8) ? 8 : len_code;
            need = idlen + 2 + (rm ? 0 : 2 * nb);
            if (!bad_hex && pos >= need) begin
                r = '0;
                r.kind = KIND_FRAME;
                r.id = id_acc;
                r.len = len_code;
                r.ext = idlen == 8;
                r.rmt = rm;
                r.data = rm ? '0 : data_acc;
                pending_results.push_back(r);
                push_char("z");
                resp = slcan_pkg::CH_CR;
            end
        end else begin
            case (cmd)
                "S": resp = (pos >= 2 && arg == "4") ? slcan_pkg::CH_CR : slcan_pkg::CH_BELL;
                "Z": resp = (pos >= 2 && hex_value(arg) >= 0) ? slcan_pkg::CH_CR
                                                             : slcan_pkg::CH_BELL;
                "V", "v": begin
                    push_char(cmd); push_hex(8'h01); push_hex(8'h00);
                    resp = slcan_pkg::CH_CR;
                end
                "N": begin
                    push_char("N"); push_hex(8'hFF); push_hex(8'hFF);
                    resp = slcan_pkg::CH_CR;
                end
                "F": begin
                    push_char("F"); push_hex(ovf ? 8'h08 : 8'h00);
                    ovf = 0;
                    resp = slcan_pkg::CH_CR;
                end
                "s", "O", "l", "L", "C", "q", "Q", "P", "a", "A", "g", "G", "m", "M":
                    resp = slcan_pkg::CH_CR;
                default: resp = slcan_pkg::CH_BELL;
            endcase
        end
        push_char(resp);
        clear_line();
    endtask

    // Format a received frame as text
    task automatic format_frame(t_request q);
        int n;
        n = (q.rx_len > 8) ? 8 : q.rx_len;
        if (q.space < 2 * n + 5) begin
            ovf = 1;
            return;
        end
        push_char("t");
        push_char(hex_digit(q.rx_id[11:8]));
        push_hex(q.rx_id[7:0]);
        push_char(hex_digit(4'(n)));
        for (int i = 0; i < n; i++) push_hex(q.rx_data[8 * i +: 8]);
        push_char(slcan_pkg::CH_CR);
    endtask

    task automatic predict(t_request q);
        int base_n;
        base_n = pending_results.size();
        if (q.op == OP_FRAME) format_frame(q);
        else if (q.eol) run_line();
        else parse_char(q.ch);
        if (pending_results.size() > base_n)
            pending_results[pending_results.size() - 1].last = 1'b1;
        if (q.known_ch != 0 && !(pending_results.size() == base_n + 1 &&
                pending_results[base_n].ch == q.known_ch)) begin
            $display("%0t table row expects single char %0d, model disagrees",
                     $time, q.known_ch);
            errors++;
        end
    endtask

    function automatic t_request ch_req(logic [7:0] c);
        t_request q;
        q = '{default: '0};
        q.op = OP_CHAR;
        q.ch = c;
        q.rx_id = 12'($urandom);
        q.rx_data = {$urandom, $urandom};
        q.space = 8'($urandom);
        return q;
    endfunction

    function automatic t_request eol_req(logic [7:0] known);
        t_request q;
        q = ch_req(8'($urandom));
        q.eol = 1;
        q.known_ch = known;
        return q;
    endfunction

    function automatic t_request frame_req(logic [11:0] id, logic [3:0] l,
                                           logic [63:0] d, logic [7:0] sp);
        t_request q;
        q = '{default: '0};
        q.op = OP_FRAME;
        q.ch = 8'($urandom);
        q.eol = 1'($urandom);
        q.rx_id = id;
        q.rx_len = l;
        q.rx_data = d;
        q.space = sp;
        return q;
    endfunction

    task automatic add_line(string s, logic [7:0] known);
        for (int i = 0; i < s.len(); i++) stim.push_back(ch_req(s[i]));
        stim.push_back(eol_req(known));
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v >= 10 && $urandom_range(0, 1)) return 8'("a" + v - 10);
        return hex_digit(4'(v));
    endfunction

    // Random well-formed frame line, sometimes damaged, cut short or overlong
    task automatic add_random_frame_line();
        string cmds;
        logic [7:0] c;
        int idlen, nb, total, mode;
        cmds = "tTrR";
        c = cmds[$urandom_range(0, 3)];
        idlen = (c < "Z") ? 8 : 3;
        nb = $urandom_range(0, 9);
        total = 1 + idlen + 1 + ((c == "r" || c == "R") ? 0 : 2 * (nb > 8 ? 8 : nb));
        mode = $urandom_range(0, 9);
        if (mode == 0) total = $urandom_range(1, total - 1);
        else if (mode == 1) total += $urandom_range(1, 4);
        for (int p = 0; p < total; p++) begin
            logic [7:0] ch;
            if (p == 0) ch = c;
            else if (p == idlen + 1) ch = (nb > 9) ? "F" : hex_digit(4'(nb));
            else ch = rand_hex();
            if (mode == 2 && p > 0 && $urandom_range(0, 5) == 0) ch = 8'($urandom);
            stim.push_back(ch_req(ch));
        end
        stim.push_back(eol_req(0));
    endtask

    task automatic build_stimulus();
        int kind;
        string cmds;
        cmds = "SZVvNFsOlLCqQPaAgGmMx";
        add_line("", slcan_pkg::CH_BELL);
        add_line("t1238112233445566778", 0);
        add_line("T1FFFFFFF0", 0);
        add_line("r7FF8", 0);
        add_line("R0000000A2", 0);
        add_line("t12G0", slcan_pkg::CH_BELL);
        add_line("t12", slcan_pkg::CH_BELL);
        add_line("S4", slcan_pkg::CH_CR);
        add_line("S9", slcan_pkg::CH_BELL);
        add_line("Zf", slcan_pkg::CH_CR);
        add_line("Z", slcan_pkg::CH_BELL);
        add_line("O", slcan_pkg::CH_CR);
        add_line("V", 0);
        add_line("N", 0);
        add_line("?", slcan_pkg::CH_BELL);
        stim.push_back(frame_req(12'hFFF, 4'hF, '1, 8'd20));
        stim.push_back(frame_req(12'hFFF, 4'hF, '1, 8'd21));
        stim.push_back(frame_req(12'h000, 4'h0, '0, 8'd4));
        add_line("F", 0);
        add_line("F", 0);
        for (int i = 0; i < 20; i++) stim.push_back(ch_req("x"));
        stim.push_back(eol_req(slcan_pkg::CH_BELL));
        while (stim.size() < 270) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                add_random_frame_line();
            end else if (kind < 8) begin
                stim.push_back(frame_req(12'($urandom), 4'($urandom),
                    {$urandom, $urandom},
                    $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(15, 255))));
            end else if (kind == 8) begin
                stim.push_back(ch_req(cmds[$urandom_range(0, cmds.len() - 1)]));
                if ($urandom_range(0, 1)) stim.push_back(ch_req(8'($urandom)));
                stim.push_back(eol_req(0));
            end else begin
                stim.push_back(ch_req(8'($urandom)));
                if ($urandom_range(0, 3) == 0) stim.push_back(eol_req(0));
            end
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender
    initial begin
        t_request q;
        int gap, sent;
        sent = 0;
        clear_line();
        ovf = 0;
        build_stimulus();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (stim.size() > 0) begin
            q = stim.pop_front();
            gap = (sent > 120 && sent < 180) ? 0 : gap_len();
            // Drain every pending result before going on
            if (sent == 200) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_op <= q.op;
            i_char_in <= q.ch;
            i_end_of_line <= q.eol;
            i_rx_id <= q.rx_id;
            i_rx_length <= q.rx_len;
            i_rx_data <= q.rx_data;
            i_tx_space <= q.space;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            predict(q);
            sent++;
        end
        i_valid <= 1'b0;
        in_done = 1;
    end

    // Receiver
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) continue;
            gap = gap_len();
            if (gap > 0 && $urandom_range(0, 1)) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_out_kind, o_out_char, o_frame_id, o_frame_length,
                    o_frame_extended, o_frame_remote, o_frame_data, o_last};
            #1;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want !== got) begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // Watchdog and end of run
    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (in_done && pending_results.size() == 0) break;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
